>>> rtl/dabt_pkg.sv
// ----------------------------------------------------------------------------
// dabt_pkg
// Shared types, widths, register indexes and rounding helpers of the
// damped two-axis alpha-beta tracker.
// ----------------------------------------------------------------------------
package dabt_pkg;

  localparam int POS_W  = 32;
  localparam int VEL_W  = 48;
  localparam int GAIN_W = 25;
  localparam int ACC_W  = 64;
  localparam int CNT_W  = 32;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DACC_W = 74;
  localparam int SUM_W  = 50;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_POS_GAIN_COMPLETE = 3'd0;
  localparam logic [IDX_W-1:0] REG_POS_GAIN_PARTIAL  = 3'd1;
  localparam logic [IDX_W-1:0] REG_VEL_GAIN_COMPLETE = 3'd2;
  localparam logic [IDX_W-1:0] REG_VEL_GAIN_PARTIAL  = 3'd3;
  localparam logic [IDX_W-1:0] REG_VEL_DAMPING       = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 25'h100_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_ADV,
    ST_E0,
    ST_E1,
    ST_E2,
    ST_E3,
    ST_E4,
    ST_FIN
  } st_t;

  // Saturate a wide signed sum to position width.
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh7FFF_FFFF);
    lo = -hi - SUM_W'(1);
    if (s > hi) return POS_W'(hi);
    else if (s < lo) return POS_W'(lo);
    else return s[POS_W-1:0];
  endfunction

  // Saturate a wide signed sum to velocity width.
  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh7FFF_FFFF_FFFF);
    lo = -hi - SUM_W'(1);
    if (s > hi) return VEL_W'(hi);
    else if (s < lo) return VEL_W'(lo);
    else return s[VEL_W-1:0];
  endfunction

  // Round the damped velocity magnitude (Q.24 product), cap and restore sign.
  function automatic logic [VEL_W-1:0] rnd_damp(input logic [DACC_W-1:0] p,
                                                 input logic neg);
    logic [DACC_W:0]     t;
    logic [DACC_W-24:0]  q;
    logic [DACC_W-24:0]  cap;
    t   = {1'b0, p} + (DACC_W+1)'(24'h80_0000);
    q   = t[DACC_W:24];
    cap = neg ? (DACC_W-23)'(48'h8000_0000_0000) : (DACC_W-23)'(48'h7FFF_FFFF_FFFF);
    if (q > cap) q = cap;
    return neg ? (VEL_W'(0) - q[VEL_W-1:0]) : q[VEL_W-1:0];
  endfunction

  // Apply a rounded signed magnitude term to a sign-extended base.
  function automatic logic signed [SUM_W-1:0] signed_term(input logic [SUM_W-2:0] q,
                                                          input logic neg);
    logic signed [SUM_W-1:0] t;
    t = $signed({1'b0, q});
    return neg ? -t : t;
  endfunction

  // Advance position by velocity shifted down eight bits, rounded half away.
  function automatic logic [POS_W-1:0] adv_est(input logic [POS_W-1:0] est,
                                               input logic [VEL_W-1:0] spd);
    logic              neg;
    logic [VEL_W-1:0]  mag;
    logic [VEL_W:0]    t;
    logic signed [SUM_W-1:0] s;
    neg = spd[VEL_W-1];
    mag = neg ? (VEL_W'(0) - spd) : spd;
    t   = {1'b0, mag} + (VEL_W+1)'(8'h80);
    s   = SUM_W'($signed(est)) + signed_term((SUM_W-1)'(t[VEL_W:8]), neg);
    return sat_pos(s);
  endfunction

  // Position correction: round(prod / 2^24) with sign, saturated add.
  function automatic logic [POS_W-1:0] corr_est(input logic [POS_W-1:0] est,
                                                input logic [PROD_W-1:0] p,
                                                input logic neg);
    logic [PROD_W:0] t;
    logic signed [SUM_W-1:0] s;
    t = {1'b0, p} + (PROD_W+1)'(24'h80_0000);
    s = SUM_W'($signed(est)) + signed_term((SUM_W-1)'(t[PROD_W:24]), neg);
    return sat_pos(s);
  endfunction

  // Velocity correction: round(prod / 2^16) with sign, saturated add.
  function automatic logic [VEL_W-1:0] corr_spd(input logic [VEL_W-1:0] spd,
                                                input logic [PROD_W-1:0] p,
                                                input logic neg);
    logic [PROD_W:0] t;
    logic signed [SUM_W-1:0] s;
    t = {1'b0, p} + (PROD_W+1)'(16'h8000);
    s = SUM_W'($signed(spd)) + signed_term((SUM_W-1)'(t[PROD_W:16]), neg);
    return sat_vel(s);
  endfunction

  // Saturating unsigned accumulate of a squared error.
  function automatic logic [ACC_W-1:0] acc_sat(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

endpackage

>>> rtl/damped_alpha_beta_tracker_2d_core.sv
// ----------------------------------------------------------------------------
// damped_alpha_beta_tracker_2d_core
// Two-axis alpha-beta tracker with velocity damping and error scoring.
// ----------------------------------------------------------------------------
// One request yields one result. A request that arrives before the tracker is
// seeded goes from accept straight to the result state; a tracked request is
// run by a sequencer that takes both axes through one shared 32x32 multiplier
// (two products for the velocity damping, then squared error, position gain
// and velocity gain products per axis). The input is not ready while a
// request is in work; a finished result waits in the output register and the
// next request is accepted meanwhile. Gains are unsigned Q.24; the user must
// write them only while the block is idle, as the block does not enforce it.
module damped_alpha_beta_tracker_2d_core import dabt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [GAIN_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [POS_W-1:0]    in_meas_y,
  input  logic [POS_W-1:0]    in_meas_x,
  input  logic                in_rejected,
  input  logic                in_inferred,
  input  logic                in_last_record,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [POS_W-1:0]    out_pred_y,
  output logic [POS_W-1:0]    out_pred_x,
  output logic                out_tracking,
  output logic                out_scored,
  output logic [ACC_W-1:0]    out_sum_sq_err_y,
  output logic [ACC_W-1:0]    out_sum_sq_err_x,
  output logic [CNT_W-1:0]    out_score_count,
  output logic                out_set_done
);

  st_t state_r, state_nxt;

  logic [GAIN_W-1:0] pgc_r, pgp_r, vgc_r, vgp_r, damp_r;

  logic              seeded_r, after_gap_r;
  logic [POS_W-1:0]  est_r   [2];
  logic [VEL_W-1:0]  speed_r [2];
  logic [ACC_W-1:0]  err_r   [2];
  logic [CNT_W-1:0]  cnt_r;

  logic [POS_W-1:0]  z_r     [2];
  logic [POS_W-1:0]  pred_r  [2];
  logic              rej_r, cmpl_r, last_r, track_r, score_r;
  logic              ax_r;
  logic              sneg_r;
  logic [DACC_W-1:0] dacc_r;
  logic              eneg_r;
  logic [POS_W-1:0]  emag_r;

  logic              out_valid_r;
  logic              fin_go;
  logic              accept;
  logic              in_cmpl;

  logic [MUL_W-1:0]  op_a, op_b;
  logic [PROD_W-1:0] prod_r;
  logic [VEL_W-1:0]  smag;
  logic [GAIN_W-1:0] gain_a, gain_b;
  logic signed [POS_W:0] ediff;

  dabt_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign accept  = in_valid && in_ready;
  assign in_cmpl = !in_rejected && !in_inferred;
  assign fin_go  = !out_valid_r || out_ready;
  assign smag    = speed_r[ax_r][VEL_W-1] ? (VEL_W'(0) - speed_r[ax_r]) : speed_r[ax_r];
  assign gain_a  = cmpl_r ? pgc_r : pgp_r;
  assign gain_b  = cmpl_r ? vgc_r : vgp_r;
  assign ediff   = $signed({z_r[ax_r][POS_W-1], z_r[ax_r]})
                 - $signed({est_r[ax_r][POS_W-1], est_r[ax_r]});

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = seeded_r ? ST_D0 : ST_FIN;
      end
      ST_D0:  state_nxt = ST_D1;
      ST_D1:  state_nxt = ST_D2;
      ST_D2:  state_nxt = ST_D3;
      ST_D3:  state_nxt = ST_ADV;
      ST_ADV: state_nxt = ST_E0;
      ST_E0:  state_nxt = ST_E1;
      ST_E1:  state_nxt = ST_E2;
      ST_E2:  state_nxt = ST_E3;
      ST_E3:  state_nxt = ST_E4;
      ST_E4:  state_nxt = ax_r ? ST_FIN : ST_D0;
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and multiplier operand select
  always_comb begin
    in_ready = 1'b0;
    op_a     = '0;
    op_b     = '0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_D0: begin
        op_a = MUL_W'(smag[23:0]);
        op_b = MUL_W'(damp_r);
      end
      ST_D1: begin
        op_a = MUL_W'(smag[VEL_W-1:24]);
        op_b = MUL_W'(damp_r);
      end
      ST_E1: begin
        op_a = emag_r;
        op_b = emag_r;
      end
      ST_E2: begin
        op_a = emag_r;
        op_b = MUL_W'(gain_a);
      end
      ST_E3: begin
        op_a = emag_r;
        op_b = MUL_W'(gain_b);
      end
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pgc_r  <= GAIN_ONE;
      pgp_r  <= '0;
      vgc_r  <= '0;
      vgp_r  <= '0;
      damp_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_POS_GAIN_COMPLETE: pgc_r  <= cfg_wdata;
        REG_POS_GAIN_PARTIAL:  pgp_r  <= cfg_wdata;
        REG_VEL_GAIN_COMPLETE: vgc_r  <= cfg_wdata;
        REG_VEL_GAIN_PARTIAL:  vgp_r  <= cfg_wdata;
        REG_VEL_DAMPING:       damp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer state, filter state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seeded_r    <= 1'b0;
      after_gap_r <= 1'b0;
      est_r[0]    <= '0;
      est_r[1]    <= '0;
      speed_r[0]  <= '0;
      speed_r[1]  <= '0;
      err_r[0]    <= '0;
      err_r[1]    <= '0;
      cnt_r       <= '0;
      ax_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && state_r != ST_FIN) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            z_r[0]    <= in_meas_y;
            z_r[1]    <= in_meas_x;
            pred_r[0] <= '0;
            pred_r[1] <= '0;
            rej_r     <= in_rejected;
            cmpl_r    <= in_cmpl;
            last_r    <= in_last_record;
            track_r   <= seeded_r;
            score_r   <= seeded_r && in_cmpl && after_gap_r;
            ax_r      <= 1'b0;
            // seed the position from the first complete measurement
            if (!seeded_r && in_cmpl) begin
              est_r[0] <= in_meas_y;
              est_r[1] <= in_meas_x;
              seeded_r <= 1'b1;
            end
          end
        end
        ST_D0: sneg_r <= speed_r[ax_r][VEL_W-1];
        ST_D1: dacc_r <= DACC_W'(prod_r);
        ST_D2: dacc_r <= dacc_r + {prod_r[DACC_W-25:0], 24'd0};
        ST_D3: speed_r[ax_r] <= rnd_damp(dacc_r, sneg_r);
        ST_ADV: begin
          est_r[ax_r]  <= adv_est(est_r[ax_r], speed_r[ax_r]);
          pred_r[ax_r] <= adv_est(est_r[ax_r], speed_r[ax_r]);
        end
        ST_E0: begin
          eneg_r <= ediff[POS_W];
          emag_r <= ediff[POS_W] ? POS_W'(-ediff) : POS_W'(ediff);
        end
        ST_E1: ;
        ST_E2: begin
          if (score_r) err_r[ax_r] <= acc_sat(err_r[ax_r], prod_r);
        end
        ST_E3: begin
          if (!rej_r) est_r[ax_r] <= corr_est(est_r[ax_r], prod_r, eneg_r);
        end
        ST_E4: begin
          if (!rej_r) speed_r[ax_r] <= corr_spd(speed_r[ax_r], prod_r, eneg_r);
          ax_r <= 1'b1;
        end
        ST_FIN: begin
          if (fin_go) begin
            out_valid_r      <= 1'b1;
            out_pred_y       <= pred_r[0];
            out_pred_x       <= pred_r[1];
            out_tracking     <= seeded_r;
            out_scored       <= score_r;
            out_sum_sq_err_y <= err_r[0];
            out_sum_sq_err_x <= err_r[1];
            out_score_count  <= (score_r && cnt_r != {CNT_W{1'b1}}) ? cnt_r + CNT_W'(1) : cnt_r;
            out_set_done     <= last_r;
            // drop all tracking state at the end of a set
            if (last_r) begin
              seeded_r    <= 1'b0;
              after_gap_r <= 1'b0;
              est_r[0]    <= '0;
              est_r[1]    <= '0;
              speed_r[0]  <= '0;
              speed_r[1]  <= '0;
              err_r[0]    <= '0;
              err_r[1]    <= '0;
              cnt_r       <= '0;
            end else begin
              if (score_r && cnt_r != {CNT_W{1'b1}}) cnt_r <= cnt_r + CNT_W'(1);
              if (track_r) after_gap_r <= !cmpl_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/dabt_mul.sv
// ----------------------------------------------------------------------------
// dabt_mul
// Shared unsigned 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module dabt_mul import dabt_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

>>> rtl/dabt_checker.sv
// ----------------------------------------------------------------------------
// dabt_checker
// Port-level checks of the tracker core, bound into the core module.
// ----------------------------------------------------------------------------
module dabt_checker import dabt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [POS_W-1:0] out_pred_y,
  input logic [POS_W-1:0] out_pred_x,
  input logic             out_tracking,
  input logic             out_scored,
  input logic [CNT_W-1:0] out_score_count
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pred_y) && $stable(out_pred_x)
      && $stable(out_score_count))
    else $error("stalled result changed");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scored |-> out_tracking && out_score_count != '0)
    else $error("scored result without tracking or count");

  a_untracked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tracking |-> out_pred_y == '0 && out_pred_x == '0 && !out_scored)
    else $error("untracked result carries a prediction");

endmodule

bind damped_alpha_beta_tracker_2d_core dabt_checker u_dabt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pred_y      (out_pred_y),
  .out_pred_x      (out_pred_x),
  .out_tracking    (out_tracking),
  .out_scored      (out_scored),
  .out_score_count (out_score_count)
);

>>> tb/damped_alpha_beta_tracker_2d_core_test.sv
// ----------------------------------------------------------------------------
// damped_alpha_beta_tracker_2d_core_test
// Self-checking bench for the two-axis damped alpha-beta tracker. A scoreboard
// predicts every result from the accepted requests and the gains, and checks
// the results in order while both sides idle at random across gain settings.
// ----------------------------------------------------------------------------
module damped_alpha_beta_tracker_2d_core_test;
  import dabt_pkg::*;

  typedef struct {
    logic [POS_W-1:0] pred_y;
    logic [POS_W-1:0] pred_x;
    logic             tracking;
    logic             scored;
    logic [ACC_W-1:0] sum_y;
    logic [ACC_W-1:0] sum_x;
    logic [CNT_W-1:0] count;
    logic             set_done;
  } track_result_t;

  class track_scoreboard;
    logic [GAIN_W-1:0] gain[5];
    bit                seeded;
    bit                after_gap;
    longint            est[2];
    longint            speed[2];
    bit [ACC_W-1:0]    err_sum[2];
    bit [CNT_W-1:0]    scores;
    track_result_t     expected_q[$];
    int                errors;

    function new();
      gain[REG_POS_GAIN_COMPLETE] = GAIN_ONE;
      gain[REG_POS_GAIN_PARTIAL]  = '0;
      gain[REG_VEL_GAIN_COMPLETE] = '0;
      gain[REG_VEL_GAIN_PARTIAL]  = '0;
      gain[REG_VEL_DAMPING]       = '0;
      clear_track();
      errors = 0;
    endfunction

    function void clear_track();
      seeded = 0;
      after_gap = 0;
      est[0] = 0; est[1] = 0;
      speed[0] = 0; speed[1] = 0;
      err_sum[0] = '0; err_sum[1] = '0;
      scores = '0;
    endfunction

    // round(v * g / 2^f), ties away from zero, capped to w signed bits
    function longint scale_round(longint v, logic [GAIN_W-1:0] g, int f, int w);
      bit         neg;
      bit [63:0]  mag;
      bit [127:0] p;
      bit [127:0] cap;
      neg = v < 0;
      mag = neg ? 64'(0) - 64'(v) : 64'(v);
      p = {64'b0, mag} * {103'b0, g};
      p = (p + (128'd1 << (f - 1))) >> f;
      cap = (128'd1 << (w - 1)) - (neg ? 128'd0 : 128'd1);
      if (p > cap) p = cap;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function longint clamp_add(longint a, longint b, int w);
      logic signed [65:0] s;
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      s = 66'(a) + 66'(b);
      hi = (66'sd1 <<< (w - 1)) - 66'sd1;
      lo = -hi - 66'sd1;
      if (s > hi) s = hi;
      else if (s < lo) s = lo;
      return longint'(s[63:0]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [POS_W-1:0] my, logic [POS_W-1:0] mx,
                               bit rej, bit inf, bit last);
      longint        z[2];
      longint        pred[2];
      longint        e;
      bit [63:0]     m;
      bit [63:0]     sq;
      bit [64:0]     s;
      bit            complete;
      bit            hit;
      logic [GAIN_W-1:0] pg;
      logic [GAIN_W-1:0] vg;
      track_result_t r;
      z[0] = longint'($signed(my));
      z[1] = longint'($signed(mx));
      pred[0] = 0; pred[1] = 0;
      complete = !rej && !inf;
      hit = 0;
      if (!seeded) begin
        if (complete) begin
          est[0] = z[0];
          est[1] = z[1];
          seeded = 1;
        end
      end else begin
        for (int j = 0; j < 2; j++) begin
          speed[j] = scale_round(speed[j], gain[REG_VEL_DAMPING], 24, VEL_W);
          est[j] = clamp_add(est[j], scale_round(speed[j], 1, 8, 64), POS_W);
          pred[j] = est[j];
        end
        if (complete && after_gap) begin
          for (int j = 0; j < 2; j++) begin
            e = est[j] - z[j];
            m = e < 0 ? 64'(0) - 64'(e) : 64'(e);
            sq = m > 64'hFFFF_FFFF ? '1 : m * m;
            s = {1'b0, err_sum[j]} + {1'b0, sq};
            err_sum[j] = s[64] ? '1 : s[63:0];
          end
          if (scores != '1) scores++;
          hit = 1;
        end
        if (!rej) begin
          pg = complete ? gain[REG_POS_GAIN_COMPLETE] : gain[REG_POS_GAIN_PARTIAL];
          vg = complete ? gain[REG_VEL_GAIN_COMPLETE] : gain[REG_VEL_GAIN_PARTIAL];
          for (int j = 0; j < 2; j++) begin
            e = z[j] - est[j];
            est[j] = clamp_add(est[j], scale_round(e, pg, 24, 64), POS_W);
            speed[j] = clamp_add(speed[j], scale_round(e, vg, 16, 64), VEL_W);
          end
        end
        after_gap = !complete;
      end
      r.pred_y = pred[0][POS_W-1:0];
      r.pred_x = pred[1][POS_W-1:0];
      r.tracking = seeded;
      r.scored = hit;
      r.sum_y = err_sum[0];
      r.sum_x = err_sum[1];
      r.count = scores;
      r.set_done = last;
      expected_q.push_back(r);
      if (last) clear_track();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(track_result_t got);
      track_result_t w;
      if (expected_q.size() == 0) begin
        report("result with no request pending");
      end else begin
        w = expected_q.pop_front();
        if (got.pred_y !== w.pred_y) report($sformatf("pred_y %h exp %h", got.pred_y, w.pred_y));
        if (got.pred_x !== w.pred_x) report($sformatf("pred_x %h exp %h", got.pred_x, w.pred_x));
        if (got.tracking !== w.tracking) report($sformatf("tracking %b exp %b", got.tracking, w.tracking));
        if (got.scored !== w.scored) report($sformatf("scored %b exp %b", got.scored, w.scored));
        if (got.sum_y !== w.sum_y) report($sformatf("sum_y %h exp %h", got.sum_y, w.sum_y));
        if (got.sum_x !== w.sum_x) report($sformatf("sum_x %h exp %h", got.sum_x, w.sum_x));
        if (got.count !== w.count) report($sformatf("count %0d exp %0d", got.count, w.count));
        if (got.set_done !== w.set_done) report($sformatf("set_done %b exp %b", got.set_done, w.set_done));
      end
    endtask
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_wr_en = 0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [GAIN_W-1:0] cfg_wdata = '0;
  logic              in_valid = 0;
  logic              in_ready;
  logic [POS_W-1:0]  in_meas_y = '0;
  logic [POS_W-1:0]  in_meas_x = '0;
  logic              in_rejected = 0;
  logic              in_inferred = 0;
  logic              in_last_record = 0;
  logic              out_valid;
  logic              out_ready = 0;
  logic [POS_W-1:0]  out_pred_y;
  logic [POS_W-1:0]  out_pred_x;
  logic              out_tracking;
  logic              out_scored;
  logic [ACC_W-1:0]  out_sum_sq_err_y;
  logic [ACC_W-1:0]  out_sum_sq_err_x;
  logic [CNT_W-1:0]  out_score_count;
  logic              out_set_done;

  int send_idle = 6;
  int recv_idle = 56;
  int sent = 0;
  track_scoreboard sb = new();

  damped_alpha_beta_tracker_2d_core dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    track_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.pred_y = out_pred_y;
      got.pred_x = out_pred_x;
      got.tracking = out_tracking;
      got.scored = out_scored;
      got.sum_y = out_sum_sq_err_y;
      got.sum_x = out_sum_sq_err_x;
      got.count = out_score_count;
      got.set_done = out_set_done;
      sb.check_result(got);
    end
  end

  // valid stays high between back-to-back requests; drop it only for a gap
  task send_request(logic [POS_W-1:0] my, logic [POS_W-1:0] mx, bit rej, bit inf, bit last);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1;
    in_meas_y <= my;
    in_meas_x <= mx;
    in_rejected <= rej;
    in_inferred <= inf;
    in_last_record <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(my, mx, rej, inf, last);
    sent++;
  endtask

  task drain();
    in_valid <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task write_gain(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.gain[idx] = val;
  endtask

  function logic [GAIN_W-1:0] pick_gain(int style);
    int r;
    r = (style < 3) ? style : $urandom_range(5);
    case (r)
      0: return '0;
      1: return GAIN_ONE;
      2: return '1;
      default: return GAIN_W'($urandom_range(GAIN_ONE));
    endcase
  endfunction

  // A set: an optional untracked lead-in, then a noisy straight-line track.
  task send_set(int len);
    logic signed [31:0] py;
    logic signed [31:0] px;
    logic signed [31:0] vy;
    logic signed [31:0] vx;
    logic [31:0]        my;
    logic [31:0]        mx;
    int                 r;
    bit                 rej;
    bit                 inf;
    py = $signed($urandom_range(32'h3FFF_FFFF)) - 32'sh2000_0000;
    px = $signed($urandom_range(32'h3FFF_FFFF)) - 32'sh2000_0000;
    vy = $signed($urandom_range(32'h7_FFFF)) - 32'sh4_0000;
    vx = $signed($urandom_range(32'h7_FFFF)) - 32'sh4_0000;
    for (int i = 0; i < len; i++) begin
      py += vy;
      px += vx;
      r = $urandom_range(99);
      rej = (r >= 82);
      inf = (r >= 68 && r < 82) || r >= 95;
      if ($urandom_range(19) == 0) begin
        my = $urandom;
        mx = $urandom;
      end else begin
        my = py + $signed($urandom_range(32'h1_FFFF)) - 32'sh1_0000;
        mx = px + $signed($urandom_range(32'h1_FFFF)) - 32'sh1_0000;
      end
      send_request(my, mx, rej, inf, i == len - 1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, flag combinations, seed and restart
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0);
    send_request(32'h1234_0000, 32'h0000_0001, 0, 1, 0);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 0);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
    send_request(32'h0000_0000, 32'hFFFF_FFFF, 1, 1, 0);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1);
    send_request(32'h0001_0000, 32'hFFFF_0000, 1, 1, 1);
    send_request(32'h0001_0000, 32'hFFFF_0000, 0, 0, 0);
    send_request(32'h0002_0000, 32'hFFFE_0000, 0, 1, 0);
    send_request(32'h0003_0000, 32'hFFFD_0000, 0, 0, 0);
    send_request(32'h0004_0000, 32'hFFFC_0000, 0, 0, 1);
    drain();
    write_gain(REG_VEL_DAMPING, '1);
    write_gain(REG_VEL_GAIN_COMPLETE, '1);
    write_gain(REG_VEL_GAIN_PARTIAL, '1);
    write_gain(REG_POS_GAIN_PARTIAL, '1);
    cfg_wr_en <= 0;
    send_request(32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 0);
    send_request(32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 0);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
    send_request(32'h0000_0000, 32'h0000_0000, 1, 0, 1);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph == 2) begin
        send_idle = 56;
        recv_idle = 6;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int k = 0; k < 5; k++) write_gain(IDX_W'(k), pick_gain(ph));
      // damping below one keeps most tracks stable
      if (ph >= 3 && $urandom_range(1)) write_gain(REG_VEL_DAMPING, GAIN_W'(
        $urandom_range(GAIN_ONE - 1, GAIN_ONE / 2)));
      cfg_wr_en <= 0;
      while (sent < 20 + (ph + 1) * 250) send_set($urandom_range(20, 1));
    end

    drain();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/dabt_pkg.sv
rtl/dabt_mul.sv
rtl/damped_alpha_beta_tracker_2d_core.sv
rtl/dabt_checker.sv
tb/damped_alpha_beta_tracker_2d_core_test.sv
